// ===== rtl/dpsa_pkg.sv =====
package dpsa_pkg;

    localparam int INDEX_W  = 6;
    localparam int GRANT_W  = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    // controller -> datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SCAN_ALLOC,
        OP_SCAN_PROBE,
        OP_STEP,
        OP_ALLOC_DONE,
        OP_FREE_BAD,
        OP_FREE_CLEAR,
        OP_SHRINK_DONE
    } dp_op_t;

    // datapath -> controller status
    typedef struct packed {
        logic is_free;
        logic mark_zero;
        logic idx_bad;
        logic scan_done;
        logic scan_hit;
        logic shrink_go;
    } dp_stat_t;

endpackage

// ===== rtl/dpsa_ctrl.sv =====
module dpsa_ctrl
    import dpsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_op_t   op,
    output logic     busy,
    output logic     done
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_SCAN_A = 6'b000100,
        S_SCAN_P = 6'b001000,
        S_SCAN_S = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_CAPTURE;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (!stat.is_free)
                begin
                    if (stat.mark_zero)
                    begin
                        op         = OP_ALLOC_DONE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        op         = OP_SCAN_ALLOC;
                        state_next = S_SCAN_A;
                    end
                end
                else if (stat.idx_bad)
                begin
                    op         = OP_FREE_BAD;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = OP_SCAN_PROBE;
                    state_next = S_SCAN_P;
                end
            end
            S_SCAN_A:
            begin
                op = OP_STEP;
                if (stat.scan_done)
                begin
                    op         = OP_ALLOC_DONE;
                    state_next = S_DONE;
                end
            end
            S_SCAN_P:
            begin
                op = OP_STEP;
                if (stat.scan_done)
                begin
                    if (!stat.scan_hit)
                    begin
                        op         = OP_FREE_BAD;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        op         = OP_FREE_CLEAR;
                        state_next = stat.shrink_go ? S_SCAN_S : S_DONE;
                    end
                end
            end
            S_SCAN_S:
            begin
                op = OP_STEP;
                if (stat.scan_done)
                begin
                    op         = OP_SHRINK_DONE;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ===== rtl/dpsa_datapath.sv =====
module dpsa_datapath
    import dpsa_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_type,
    input  logic                pool_select,
    input  logic [INDEX_W-1:0]  slot_index,
    input  dp_op_t              op,
    output dp_stat_t            stat,
    output logic [GRANT_W-1:0]  granted_slot,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  pool_count
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int MARK_W = $clog2(SLOTS + 1);
    localparam int CMP_W  = (MARK_W > COUNT_W) ? MARK_W : COUNT_W;

    // request
    logic               req_type_reg;
    logic               pool_reg;
    logic [INDEX_W-1:0] idx_reg;

    // high-water marks
    logic [MARK_W-1:0] number_mark_reg;
    logic [MARK_W-1:0] number_mark_next;
    logic [MARK_W-1:0] string_mark_reg;
    logic [MARK_W-1:0] string_mark_next;

    // downward scan: issue side and check side (one read in flight)
    logic [ADDR_W-1:0] iss_addr_reg;
    logic [ADDR_W-1:0] iss_addr_next;
    logic              iss_valid_reg;
    logic              iss_valid_next;
    logic [ADDR_W-1:0] chk_addr_reg;
    logic [ADDR_W-1:0] chk_addr_next;
    logic              chk_valid_reg;
    logic              chk_valid_next;
    logic              chk_last_reg;
    logic              chk_last_next;
    logic              target_reg;
    logic              target_next;

    // tag store, bit 0 number pool, bit 1 string pool
    logic [1:0]        tag_mem [SLOTS];
    logic [1:0]        rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_val;

    logic [GRANT_W-1:0] granted_reg;
    logic [GRANT_W-1:0] granted_next;
    status_t            status_reg;
    status_t            status_next;

    logic [MARK_W-1:0] mark_sel;
    logic [MARK_W-1:0] mark_new;
    logic              mark_upd;
    logic [CMP_W-1:0]  mark_ext;
    logic [CMP_W-1:0]  idx_ext;
    logic [ADDR_W-1:0] idx_addr;
    logic [ADDR_W-1:0] mark_top_addr;
    logic              mark_full;
    logic              top_hit;
    logic              hit;

    logic              start_en;
    logic [ADDR_W-1:0] start_addr;
    logic              start_single;
    logic              start_target;

    assign mark_sel      = pool_reg ? string_mark_reg : number_mark_reg;
    assign mark_ext      = CMP_W'(mark_sel);
    assign idx_ext       = CMP_W'(idx_reg);
    assign idx_addr      = ADDR_W'(idx_ext);
    assign mark_top_addr = ADDR_W'(mark_sel - MARK_W'(1));
    assign mark_full     = (mark_sel == MARK_W'(SLOTS));
    assign top_hit       = ((idx_ext + CMP_W'(1)) == mark_ext);
    assign hit           = chk_valid_reg && (rd_data_reg[pool_reg] == target_reg);

    always_comb
    begin
        stat.is_free   = (req_type_reg == REQ_FREE);
        stat.mark_zero = (mark_sel == '0);
        // slots at or above the mark are always free for that pool
        stat.idx_bad   = (idx_ext >= mark_ext);
        stat.scan_done = chk_valid_reg && (hit || chk_last_reg);
        stat.scan_hit  = hit;
        stat.shrink_go = top_hit && (idx_ext != '0);
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_CAPTURE)
        begin
            req_type_reg <= req_type;
            pool_reg     <= pool_select;
            idx_reg      <= slot_index;
        end
    end

    // scan launch
    always_comb
    begin
        start_en     = 1'b0;
        start_addr   = mark_top_addr;
        start_single = 1'b0;
        start_target = 1'b0;
        case (op)
            OP_SCAN_ALLOC:
            begin
                start_en = 1'b1;
            end
            OP_SCAN_PROBE:
            begin
                start_en     = 1'b1;
                start_addr   = idx_addr;
                start_single = 1'b1;
                start_target = 1'b1;
            end
            OP_FREE_CLEAR:
            begin
                start_en     = stat.shrink_go;
                start_addr   = idx_addr - ADDR_W'(1);
                start_target = 1'b1;
            end
            default:
            begin
                start_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = iss_addr_reg;
        iss_addr_next  = iss_addr_reg;
        iss_valid_next = 1'b0;
        chk_addr_next  = chk_addr_reg;
        chk_valid_next = 1'b0;
        chk_last_next  = chk_last_reg;
        target_next    = target_reg;
        if (start_en)
        begin
            rd_en          = 1'b1;
            rd_addr        = start_addr;
            chk_addr_next  = start_addr;
            chk_valid_next = 1'b1;
            chk_last_next  = start_single || (start_addr == '0);
            iss_addr_next  = start_addr - ADDR_W'(1);
            iss_valid_next = !(start_single || (start_addr == '0));
            target_next    = start_target;
        end
        else if (op == OP_STEP && iss_valid_reg)
        begin
            rd_en          = 1'b1;
            rd_addr        = iss_addr_reg;
            chk_addr_next  = iss_addr_reg;
            chk_valid_next = 1'b1;
            chk_last_next  = (iss_addr_reg == '0);
            iss_addr_next  = iss_addr_reg - ADDR_W'(1);
            iss_valid_next = (iss_addr_reg != '0);
        end
    end

    // result, tag write and mark update
    always_comb
    begin
        wr_en        = 1'b0;
        wr_addr      = chk_addr_reg;
        wr_val       = 1'b1;
        mark_upd     = 1'b0;
        mark_new     = mark_sel;
        granted_next = granted_reg;
        status_next  = status_reg;
        case (op)
            OP_ALLOC_DONE:
            begin
                if (hit)
                begin
                    wr_en        = 1'b1;
                    granted_next = GRANT_W'(chk_addr_reg);
                    status_next  = STAT_OK;
                end
                else if (!mark_full)
                begin
                    // append at the mark
                    wr_en        = 1'b1;
                    wr_addr      = ADDR_W'(mark_sel);
                    mark_upd     = 1'b1;
                    mark_new     = mark_sel + MARK_W'(1);
                    granted_next = GRANT_W'(mark_sel);
                    status_next  = STAT_OK;
                end
                else
                begin
                    granted_next = '0;
                    status_next  = STAT_FULL;
                end
            end
            OP_FREE_BAD:
            begin
                granted_next = '0;
                status_next  = STAT_BAD;
            end
            OP_FREE_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = idx_addr;
                wr_val       = 1'b0;
                // top slot at index zero: pool empties
                mark_upd     = top_hit && !stat.shrink_go;
                mark_new     = '0;
                granted_next = '0;
                status_next  = STAT_OK;
            end
            OP_SHRINK_DONE:
            begin
                mark_upd = 1'b1;
                mark_new = hit ? (MARK_W'(chk_addr_reg) + MARK_W'(1)) : '0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        number_mark_next = number_mark_reg;
        string_mark_next = string_mark_reg;
        if (mark_upd)
        begin
            if (pool_reg)
            begin
                string_mark_next = mark_new;
            end
            else
            begin
                number_mark_next = mark_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_mark_reg <= '0;
            string_mark_reg <= '0;
            iss_valid_reg   <= 1'b0;
            chk_valid_reg   <= 1'b0;
        end
        else
        begin
            number_mark_reg <= number_mark_next;
            string_mark_reg <= string_mark_next;
            iss_valid_reg   <= iss_valid_next;
            chk_valid_reg   <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_addr_reg <= iss_addr_next;
        chk_addr_reg <= chk_addr_next;
        chk_last_reg <= chk_last_next;
        target_reg   <= target_next;
        granted_reg  <= granted_next;
        status_reg   <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr][pool_reg] <= wr_val;
        end
        if (rd_en)
        begin
            rd_data_reg <= tag_mem[rd_addr];
        end
    end

    assign granted_slot = granted_reg;
    assign status       = status_reg;
    assign pool_count   = COUNT_W'(mark_sel);

endmodule

// ===== rtl/dual_pool_slot_allocator.sv =====
// Dual-pool slot allocator: number pool and string pool over one shared
// tag store of SLOTS entries, each pool with its own high-water mark.
//
// Request channel: a beat is taken on a rising edge with start high and
// busy low (req_type, pool_select, slot_index). Allocate picks the highest
// free slot below the pool's mark, else appends at the mark, else reports
// the pool full. Free clears the pool's bit and, when it was the top slot,
// walks the mark down past the free slots under it.
// Result channel: done is high for exactly one cycle with granted_slot,
// status and pool_count valid. There is no backpressure; the receiver
// must take the beat in that cycle.
// The shortest path runs from the accepting edge through the prep state
// to done; the wait beyond that is set by the tag store's single read
// port: the downward scan reads one slot per cycle (the allocate search,
// or the mark walk after a free). One request at a time; busy drops the
// cycle after done, so the next beat may start right then.
// Reset: marks go to zero. The tag store has no reset and no clearing
// pass: an entry is only read below its pool's mark, and every slot below
// a mark was written when the mark passed it, so no startup time is lost.
module dual_pool_slot_allocator
    import dpsa_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                req_type,
    input  logic                pool_select,
    input  logic [INDEX_W-1:0]  slot_index,
    output logic                done,
    output logic [GRANT_W-1:0]  granted_slot,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  pool_count
);

    dp_op_t   op;
    dp_stat_t stat;

    // sequencer: capture, probe/scan, commit, present result
    dpsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy),
        .done  (done)
    );

    // tag store, marks, scan counters and result registers
    dpsa_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_type     (req_type),
        .pool_select  (pool_select),
        .slot_index   (slot_index),
        .op           (op),
        .stat         (stat),
        .granted_slot (granted_slot),
        .status       (status),
        .pool_count   (pool_count)
    );

endmodule

// ===== bench/tb_dual_pool_slot_allocator.sv =====
module tb_dual_pool_slot_allocator
    import dpsa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;

    // pool_select codes
    localparam logic POOL_NUM = 1'b0;
    localparam logic POOL_STR = 1'b1;

    // Longest gap the sender inserts, plus worst-case scan. The watchdog
    // limit is many times that.
    localparam int LONG_GAP  = 40;
    localparam int WATCHDOG  = 20 * (LONG_GAP + SLOTS + 2);
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [GRANT_W-1:0] slot;
        status_t            stat;
        logic [COUNT_W-1:0] count;
    } slot_resp_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                req_type;
    logic                pool_select;
    logic [INDEX_W-1:0]  slot_index;
    logic                done;
    logic [GRANT_W-1:0]  granted_slot;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  pool_count;

    dual_pool_slot_allocator #(
        .SLOTS(SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .pool_select  (pool_select),
        .slot_index   (slot_index),
        .done         (done),
        .granted_slot (granted_slot),
        .status       (status),
        .pool_count   (pool_count)
    );

    // Mirror of the allocator: bit 0 of a tag = number pool, bit 1 = string
    // pool, so a pool's bit is indexed by pool_select directly.
    logic [1:0]  tag_mirror [SLOTS];
    int unsigned mark_mirror [2];

    // Responses owed by the block, oldest first.
    slot_resp_t pending_responses [$];
    slot_resp_t head_resp;

    int mismatches;
    int quiet_cycles;
    int gapless_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one request to the mirror and return the response it owes.
    function automatic slot_resp_t predict_response(logic rt, logic ps,
                                                    logic [INDEX_W-1:0] si);
        slot_resp_t  r;
        int unsigned m;
        int unsigned pick;
        bit          found;
        int          i;

        r.slot  = '0;
        r.stat  = STAT_OK;
        m       = mark_mirror[ps];
        found   = 1'b0;
        pick    = 0;
        if (rt == REQ_ALLOC)
        begin
            // highest free slot below the mark wins
            for (i = 0; i < m; i++)
                if (!tag_mirror[i][ps])
                begin
                    pick  = i;
                    found = 1'b1;
                end
            if (!found)
            begin
                if (m >= SLOTS)
                    r.stat = STAT_FULL;
                else
                begin
                    // append at the mark
                    pick            = m;
                    mark_mirror[ps] = m + 1;
                    found           = 1'b1;
                end
            end
            if (found)
            begin
                tag_mirror[pick][ps] = 1'b1;
                r.slot               = pick[GRANT_W-1:0];
            end
        end
        else if (si >= SLOTS || !tag_mirror[si][ps])
            r.stat = STAT_BAD;
        else
        begin
            tag_mirror[si][ps] = 1'b0;
            // freeing the top slot walks the mark down past free slots
            if (si + 1 == m)
            begin
                m--;
                while (m > 0 && !tag_mirror[m-1][ps])
                    m--;
                mark_mirror[ps] = m;
            end
        end
        r.count = mark_mirror[ps][COUNT_W-1:0];
        return r;
    endfunction

    // A random slot held by the pool, or any slot when it holds none.
    function automatic logic [INDEX_W-1:0] pick_held_slot(logic ps);
        int held [$];
        int i;

        for (i = 0; i < SLOTS; i++)
            if (tag_mirror[i][ps])
                held.push_back(i);
        if (held.size() == 0)
            return INDEX_W'($urandom_range(0, SLOTS - 1));
        return INDEX_W'(held[$urandom_range(0, held.size() - 1)]);
    endfunction

    // Sender gap: mostly none or short, a few long, and runs of
    // back-to-back beats.
    function automatic int idle_cycles();
        int roll;

        roll = $urandom_range(0, 99);
        if (gapless_left > 0)
        begin
            gapless_left--;
            return 0;
        end
        if (roll < 4)
        begin
            gapless_left = $urandom_range(15, 50);
            return 0;
        end
        if (roll < 45)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, LONG_GAP);
    endfunction

    // Send one request beat. Called right after the previous accepting
    // edge (or after reset), so start is only ever touched at a falling
    // edge, once per step: it stays high straight into a gapless beat.
    task automatic send_request(input logic rt, input logic ps,
                                input logic [INDEX_W-1:0] si);
        int gap;

        gap = idle_cycles();
        @(negedge clk);
        if (gap != 0)
        begin
            // idle inputs carry junk; the block must ignore it
            start       <= 1'b0;
            req_type    <= 1'($urandom_range(0, 1));
            pool_select <= 1'($urandom_range(0, 1));
            slot_index  <= INDEX_W'($urandom_range(0, SLOTS - 1));
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        req_type    <= rt;
        pool_select <= ps;
        slot_index  <= si;
        // accepted on the first rising edge that sees busy low
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_responses.push_back(predict_response(rt, ps, si));
    endtask

    // Hand-picked sequence: holes, shrink past free slots, bad frees of
    // unoccupied and never-written slots, the two pools sharing slots.
    task automatic test_directed();
        send_request(REQ_ALLOC, POOL_NUM, '0);
        send_request(REQ_ALLOC, POOL_NUM, '1);     // index ignored
        send_request(REQ_ALLOC, POOL_NUM, INDEX_W'($urandom_range(0, SLOTS - 1)));
        send_request(REQ_ALLOC, POOL_STR, '0);
        send_request(REQ_ALLOC, POOL_STR, INDEX_W'(21));
        send_request(REQ_FREE,  POOL_NUM, INDEX_W'(1));   // hole below mark
        send_request(REQ_ALLOC, POOL_NUM, '0);            // refills the hole
        send_request(REQ_FREE,  POOL_NUM, INDEX_W'(1));
        send_request(REQ_FREE,  POOL_NUM, INDEX_W'(2));   // mark walks to 1
        send_request(REQ_FREE,  POOL_NUM, INDEX_W'(1));   // already free
        send_request(REQ_FREE,  POOL_NUM, '1);            // never allocated
        send_request(REQ_FREE,  POOL_STR, '1);
        send_request(REQ_FREE,  POOL_STR, INDEX_W'(2));   // at the mark
        send_request(REQ_FREE,  POOL_NUM, '0);            // mark back to 0
        send_request(REQ_FREE,  POOL_NUM, '0);            // empty pool
        send_request(REQ_ALLOC, POOL_NUM, '1);            // shares slot 0
        send_request(REQ_FREE,  POOL_STR, '0);
        send_request(REQ_FREE,  POOL_STR, INDEX_W'(1));   // string mark to 0
        send_request(REQ_ALLOC, POOL_STR, INDEX_W'(42));
        send_request(REQ_FREE,  POOL_NUM, '0);
        send_request(REQ_FREE,  POOL_STR, '0);
    endtask

    // Fill each pool past capacity, then free the top slot and a hole under
    // it, and refill both until the pool is full again.
    task automatic test_pool_full();
        int p;
        int hole;

        for (p = 0; p < 2; p++)
        begin
            repeat (SLOTS + 2)
                send_request(REQ_ALLOC, 1'(p), INDEX_W'($urandom_range(0, SLOTS - 1)));
            hole = $urandom_range(0, SLOTS - 2);
            send_request(REQ_FREE,  1'(p), INDEX_W'(SLOTS - 1));
            send_request(REQ_FREE,  1'(p), INDEX_W'(hole));
            send_request(REQ_ALLOC, 1'(p), '0);
            send_request(REQ_ALLOC, 1'(p), '0);
            send_request(REQ_ALLOC, 1'(p), '1);   // full again
        end
    endtask

    // Free every held slot in random order; top frees cause long walks.
    task automatic test_drain_pools();
        logic ps;

        while (mark_mirror[POOL_NUM] != 0 || mark_mirror[POOL_STR] != 0)
        begin
            ps = 1'($urandom_range(0, 1));
            if (mark_mirror[ps] == 0)
                ps = ~ps;
            send_request(REQ_FREE, ps, pick_held_slot(ps));
        end
    endtask

    // Phases with a random allocate bias so pools swing between empty and
    // full. Frees mostly hit held slots or the top slot; some are junk.
    task automatic test_random_traffic(input int beats);
        int   alloc_pct;
        int   roll;
        int   n;
        logic ps;
        logic [INDEX_W-1:0] si;

        alloc_pct = 50;
        for (n = 0; n < beats; n++)
        begin
            if (n % 50 == 0)
                case ($urandom_range(0, 3))
                    0: alloc_pct = 15;
                    1: alloc_pct = 50;
                    2: alloc_pct = 75;
                    default: alloc_pct = 95;
                endcase
            ps = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < alloc_pct)
                send_request(REQ_ALLOC, ps, INDEX_W'($urandom_range(0, SLOTS - 1)));
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 65)
                    si = pick_held_slot(ps);
                else if (roll < 85 && mark_mirror[ps] != 0)
                    si = INDEX_W'(mark_mirror[ps] - 1);
                else
                    si = INDEX_W'($urandom_range(0, SLOTS - 1));
                send_request(REQ_FREE, ps, si);
            end
        end
    endtask

    // Result checker: done is a one-cycle strobe, taken at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: result beat with nothing expected: slot %0d status %0d count %0d",
                             $realtime, granted_slot, status, pool_count);
            end
            else
            begin
                head_resp = pending_responses.pop_front();
                if (granted_slot !== head_resp.slot || status !== head_resp.stat ||
                    pool_count !== head_resp.count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: result mismatch: slot %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
                                 $realtime, head_resp.slot, granted_slot, head_resp.stat,
                                 status, head_resp.count, pool_count);
                end
            end
        end
    end

    // Watchdog: any accepted beat, either side, resets the count.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $realtime, pending_responses.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int i;

        mismatches   = 0;
        quiet_cycles = 0;
        gapless_left = 0;
        for (i = 0; i < SLOTS; i++)
            tag_mirror[i] = 2'b00;
        mark_mirror[POOL_NUM] = 0;
        mark_mirror[POOL_STR] = 0;

        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_ALLOC;
        pool_select = POOL_NUM;
        slot_index  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_pool_full();
        test_drain_pools();
        test_random_traffic(700);

        @(negedge clk);
        start <= 1'b0;
        // watchdog bounds this wait
        while (pending_responses.size() != 0)
            @(posedge clk);
        // catch any stray beat after the last one expected
        repeat (SLOTS + 4) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
